@@ sv/crc32wsh_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32wsh_pkg
// types, constants and crc functions shared by the word-stream crc-32 hash
// ----------------------------------------------------------------------------
package crc32wsh_pkg;

    localparam int unsigned WordBits  = 32;
    localparam int unsigned CountBits = 3;
    localparam int unsigned HashBits  = 31;
    localparam int unsigned WordBytes = 4;

    localparam logic [WordBits-1:0]  CrcPoly      = 32'h04C1_1DB7;
    localparam logic [CountBits-1:0] CountFull    = 3'd4;
    localparam logic [CountBits-1:0] CountOne     = 3'd1;
    localparam logic [CountBits-1:0] CountTwo     = 3'd2;
    localparam logic [CountBits-1:0] CountThree   = 3'd3;
    localparam logic [CountBits-1:0] CountNone    = 3'd0;

    // one accepted input transaction
    typedef struct packed {
        logic [WordBits-1:0]  data_word;
        logic [CountBits-1:0] byte_count;
        logic                 last;
    } t_item;

    // result handed from the crc core to the output register
    typedef struct packed {
        logic                valid;
        logic [HashBits-1:0] hash_value;
    } t_result;

    typedef logic [WordBits-1:0] t_col_table [WordBits];

    // column i: the register with only bit i set, advanced by 32 msb-first steps
    function automatic t_col_table f_gen_cols();
        t_col_table      cols;
        logic [WordBits-1:0] v;
        for (int i = 0; i < WordBits; i++) begin
            v = '0;
            v[i] = 1'b1;
            for (int s = 0; s < WordBits; s++) begin
                if (v[WordBits-1]) begin
                    v = (v << 1) ^ CrcPoly;
                end else begin
                    v = v << 1;
                end
            end
            cols[i] = v;
        end
        return cols;
    endfunction

    localparam t_col_table AdvCols = f_gen_cols();

    // four byte steps folded into one xor matrix
    function automatic logic [WordBits-1:0] f_advance(input logic [WordBits-1:0] r);
        logic [WordBits-1:0] acc;
        acc = '0;
        for (int i = 0; i < WordBits; i++) begin
            if (r[i]) begin
                acc = acc ^ AdvCols[i];
            end
        end
        return acc;
    endfunction

    // keep the leading byte_count bytes, zero the rest
    function automatic logic [WordBits-1:0] f_keep_bytes(
        input logic [WordBits-1:0]  w,
        input logic [CountBits-1:0] n
    );
        logic [WordBits-1:0] res;
        case (n)
            CountNone:  res = '0;
            CountOne:   res = w & 32'hFF00_0000;
            CountTwo:   res = w & 32'hFFFF_0000;
            CountThree: res = w & 32'hFFFF_FF00;
            default:    res = w;
        endcase
        return res;
    endfunction

endpackage

@@ sv/crc32_word_stream_hash_top.sv @@
// ----------------------------------------------------------------------------
// crc32_word_stream_hash_top
// crc-32 (msb first, poly 04c11db7) hash over a stream of 32-bit words
// ----------------------------------------------------------------------------
//
// channel   direction  contents
// s_axis    in         tdata: data_word[31:0], byte_count[34:32]; tlast: last
// m_axis    out        tdata: hash_value[30:0]
//
// one word per cycle while no last word is held by a stalled result; an input
// transaction passes the input register, then the crc core into the result register
// the crc feedback is one 32x32 xor matrix plus the word xor, all combinational
// synchronous active-low reset clears valids and crc register, sets first-word flag
// a stalled result holds a last word in the input register, which then stalls
// the slave side; words that are not last pass while the result side is full
//
module crc32_word_stream_hash_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], byte_count[34:32], zero pad
    input  logic        s_axis_tlast,
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hash_value[30:0], zero pad
);

    crc32wsh_pkg::t_item   w_s_item;
    crc32wsh_pkg::t_item   w_in_item;
    logic                  w_in_valid;
    logic                  w_consume;
    logic                  w_out_free;
    crc32wsh_pkg::t_result w_result;
    logic [crc32wsh_pkg::HashBits-1:0] w_hash;

    // unpack the slave transaction
    assign w_s_item.data_word  = s_axis_tdata[31:0];
    assign w_s_item.byte_count = s_axis_tdata[34:32];
    assign w_s_item.last       = s_axis_tlast;

    crc32wsh_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_s_item),
        .i_consume (w_consume),
        .o_valid   (w_in_valid),
        .o_item    (w_in_item)
    );

    // crc state lives here; first word loads inverted, later words advance
    crc32wsh_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_in_valid),
        .i_item     (w_in_item),
        .i_out_free (w_out_free),
        .o_consume  (w_consume),
        .o_result   (w_result)
    );

    crc32wsh_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_hash   (w_hash)
    );

    assign m_axis_tdata = {1'b0, w_hash};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a last word is only folded in when the result register can take it
    a_no_result_overwrite : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && w_in_item.last) |-> w_out_free
    ) else $error("result register overwritten");

    // a fresh result follows a last word consumed by the core
    a_result_from_last : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_consume && w_in_item.last)
    ) else $error("result without a last word");

    // back-pressure on the slave side only with a held input word
    a_ready_when_empty : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_in_valid && !w_consume)
    ) else $error("slave side stalled with empty input register");

    // nothing offered straight after reset
    a_reset_quiet : assert property (
        @(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid
    ) else $error("result valid after reset");

endmodule

@@ sv/crc32wsh_in_stage.sv @@
// ----------------------------------------------------------------------------
// crc32wsh_in_stage
// input register holding one transaction for the crc core
// ----------------------------------------------------------------------------
module crc32wsh_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  crc32wsh_pkg::t_item  i_item,
    input  logic                 i_consume,
    output logic                 o_valid,
    output crc32wsh_pkg::t_item  o_item
);

    logic                r_valid;
    logic                n_valid;
    crc32wsh_pkg::t_item r_item;

    // free, or emptied this cycle by the core
    assign o_ready = !r_valid || i_consume;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_consume) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ sv/crc32wsh_core.sv @@
// ----------------------------------------------------------------------------
// crc32wsh_core
// crc register and first-word flag, one word folded in per cycle unless a last word waits for a free output slot
// ----------------------------------------------------------------------------
module crc32wsh_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  crc32wsh_pkg::t_item    i_item,
    input  logic                   i_out_free,
    output logic                   o_consume,
    output crc32wsh_pkg::t_result  o_result
);

    logic [crc32wsh_pkg::WordBits-1:0] r_crc;
    logic [crc32wsh_pkg::WordBits-1:0] n_crc;
    logic                              r_first;
    logic                              n_first;
    logic [crc32wsh_pkg::WordBits-1:0] w_word;
    logic                              w_short;

    // a last word needs a free output slot
    assign o_consume = i_valid && (!i_item.last || i_out_free);

    assign w_word  = crc32wsh_pkg::f_keep_bytes(i_item.data_word, i_item.byte_count);
    assign w_short = r_first && (i_item.byte_count < crc32wsh_pkg::CountFull);

    always_comb begin
        n_crc   = r_crc;
        n_first = r_first;
        if (o_consume) begin
            if (r_first) begin
                n_crc = ~w_word;
            end else begin
                n_crc = crc32wsh_pkg::f_advance(r_crc) ^ w_word;
            end
            n_first = i_item.last;
        end
    end

    always_comb begin
        o_result.valid = o_consume && i_item.last;
        if (w_short) begin
            o_result.hash_value = '0;
        end else begin
            o_result.hash_value = ~n_crc[crc32wsh_pkg::HashBits-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= '0;
            r_first <= 1'b1;
        end else begin
            r_crc   <= n_crc;
            r_first <= n_first;
        end
    end

endmodule

@@ sv/crc32wsh_out_stage.sv @@
// ----------------------------------------------------------------------------
// crc32wsh_out_stage
// result register driving the master side
// ----------------------------------------------------------------------------
module crc32wsh_out_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  crc32wsh_pkg::t_result                i_result,
    output logic                                 o_free,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [crc32wsh_pkg::HashBits-1:0]    o_hash
);

    logic                              r_valid;
    logic                              n_valid;
    logic [crc32wsh_pkg::HashBits-1:0] r_hash;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_result.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            r_hash <= i_result.hash_value;
        end
    end

    assign o_valid = r_valid;
    assign o_hash  = r_hash;

endmodule
